FILE: src/quaternion_view_project_macros.svh
// Assertion macros shared by the view projection RTL.
// Included by files that carry concurrent checks; defining ASSERT_OFF removes them.
`ifndef QUATERNION_VIEW_PROJECT_MACROS_SVH
`define QUATERNION_VIEW_PROJECT_MACROS_SVH
`ifndef ASSERT_OFF
`define QVP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define QVP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define QVP_ASSERT(lbl, clk, rst_n, prop, msg)
`define QVP_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: src/qvp_pkg.sv
// Types, widths, register codes and per-stage step functions of the view projection.
// No dependencies; used by qvp_rotate, qvp_measure, qvp_radius_div and the top level.
`default_nettype none
package qvp_pkg;

	localparam int V_W   = 33;  // camera-relative vector
	localparam int PA_W  = 49;  // vector times quaternion product
	localparam int SA_W  = 51;  // sum of three such products
	localparam int T_W   = 37;  // intermediate quaternion t
	localparam int PB_W  = 53;  // t times quaternion product
	localparam int SB_W  = 55;  // sum of four such products
	localparam int R_W   = 41;  // rotated coordinate
	localparam int SW_W  = 29;  // scale times screen size
	localparam int N_W   = 70;  // screen numerator
	localparam int D_W   = 54;  // screen divisor
	localparam int SC_STEPS = 20;
	localparam int SQ_STEPS = 32;
	localparam int RD_STEPS = 32;

	localparam logic signed [15:0] EYE_PLANE_POS = -16'sd1000;

	typedef enum logic [2:0] {
		REG_CAM_X, REG_CAM_Y, REG_CAM_Z,
		REG_ROT_W, REG_ROT_X, REG_ROT_Y, REG_ROT_Z,
		REG_SCALE
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic signed [31:0] cam_z;
		logic signed [15:0] rot_w;
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
	} view_cfg_t;

	typedef struct packed {
		logic signed [R_W-1:0] rx;
		logic signed [R_W-1:0] ry;
		logic signed [R_W-1:0] rz;
		logic [31:0]           radius;
	} rot_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
		logic [63:0] nsh;
		logic        sat;
	} sqrt_st_t;

	typedef struct packed {
		logic [D_W-1:0]      rem;
		logic [D_W-1:0]      d;
		logic [SC_STEPS-1:0] nsh;
		logic [SC_STEPS-1:0] q;
		logic                over;
		logic                neg;
	} scr_st_t;

	typedef struct packed {
		sqrt_st_t    sq;
		scr_st_t     scx;
		scr_st_t     scy;
		logic [31:0] radius;
		logic        behind;
		logic        plane;
	} meas_t;

	typedef struct packed {
		logic [31:0]        distance;
		logic [31:0]        radius;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic               behind;
		logic               plane;
	} geom_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] d;
		logic [31:0] nsh;
		logic [31:0] q;
		logic        sat;
	} rdiv_st_t;

	typedef struct packed {
		rdiv_st_t           dv;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic               behind;
		logic               plane;
	} rd_t;

	// Round Q.30 to Q16.16: add half an LSB, then floor shift by 14.
	function automatic logic signed [T_W-1:0] rnd_t(input logic signed [SA_W-1:0] s);
		logic signed [SA_W-1:0] a;
		a = s + SA_W'(8192);
		return T_W'(a >>> 14);
	endfunction

	function automatic logic signed [R_W-1:0] rnd_r(input logic signed [SB_W-1:0] s);
		logic signed [SB_W-1:0] a;
		a = s + SB_W'(8192);
		return R_W'(a >>> 14);
	endfunction

	function automatic logic [R_W-1:0] mag(input logic signed [R_W-1:0] v);
		return v[R_W-1] ? R_W'(-v) : R_W'(v);
	endfunction

	// One result bit of the integer square root.
	function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
		sqrt_st_t   o;
		logic [35:0] t;
		logic [35:0] trial;
		logic        ge;
		t     = {s.rem, s.nsh[63:62]};
		trial = 36'({s.root, 2'b01});
		ge    = t >= trial;
		o.rem  = ge ? 34'(t - trial) : 34'(t);
		o.root = {s.root[30:0], ge};
		o.nsh  = {s.nsh[61:0], 2'b00};
		o.sat  = s.sat;
		return o;
	endfunction

	// One quotient bit of the screen division.
	function automatic scr_st_t scr_step(input scr_st_t s);
		scr_st_t      o;
		logic [D_W:0] t;
		logic         ge;
		t  = {s.rem, s.nsh[SC_STEPS-1]};
		ge = t >= {1'b0, s.d};
		o      = s;
		o.rem  = ge ? D_W'(t - {1'b0, s.d}) : D_W'(t);
		o.q    = {s.q[SC_STEPS-2:0], ge};
		o.nsh  = {s.nsh[SC_STEPS-2:0], 1'b0};
		return o;
	endfunction

	// Adds the half-screen offset with floor rounding and saturates to 16 bits.
	function automatic logic signed [15:0] scr_final(input scr_st_t s, input logic [12:0] hw,
			input logic odd);
		logic [D_W-1:0]     half;
		logic [13:0]        add;
		logic signed [22:0] p;
		logic signed [15:0] r;
		half = s.d >> 1;
		if (!s.neg) begin
			add = {1'b0, hw} + 14'(odd & (s.rem >= half));
			p   = 23'(s.q) + 23'(add);
		end else begin
			add = {1'b0, hw} - 14'(odd ? (s.rem > half) : (s.rem != '0));
			p   = 23'(add) - 23'(s.q);
		end
		if (s.over)
			r = s.neg ? -16'sd32768 : 16'sd32767;
		else if (p > 23'sd32767)
			r = 16'sd32767;
		else if (p < -23'sd32768)
			r = -16'sd32768;
		else
			r = 16'(p);
		return r;
	endfunction

	// One quotient bit of the radius division.
	function automatic rdiv_st_t rdiv_step(input rdiv_st_t s);
		rdiv_st_t    o;
		logic [32:0] t;
		logic        ge;
		t  = {s.rem, s.nsh[31]};
		ge = t >= {1'b0, s.d};
		o     = s;
		o.rem = ge ? 32'(t - {1'b0, s.d}) : 32'(t);
		o.q   = {s.q[30:0], ge};
		o.nsh = {s.nsh[30:0], 1'b0};
		return o;
	endfunction

endpackage
`default_nettype wire

FILE: src/qvp_point_if.sv
// Request channel carrying one world point and sphere radius.
// Depends on nothing.
`default_nettype none
interface qvp_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic [31:0]        obj_radius;

	modport source(output valid, output point_x, output point_y, output point_z,
		output obj_radius, input ready);
	modport sink(input valid, input point_x, input point_y, input point_z,
		input obj_radius, output ready);
endinterface
`default_nettype wire

FILE: src/qvp_result_if.sv
// Request channel carrying one projected result.
// Depends on nothing.
`default_nettype none
interface qvp_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] screen_x;
	logic signed [15:0] screen_y;
	logic [31:0]        view_distance;
	logic [31:0]        proj_radius;
	logic               behind_camera;
	logic               on_eye_plane;

	modport source(output valid, output screen_x, output screen_y, output view_distance,
		output proj_radius, output behind_camera, output on_eye_plane, input ready);
	modport sink(input valid, input screen_x, input screen_y, input view_distance,
		input proj_radius, input behind_camera, input on_eye_plane, output ready);
endinterface
`default_nettype wire

FILE: src/qvp_rotate.sv
// Camera translation and quaternion rotation q*v*conj(q), five pipeline stages.
// Depends on qvp_pkg.
`default_nettype none
module qvp_rotate (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  logic signed [31:0]  px,
	input  logic signed [31:0]  py,
	input  logic signed [31:0]  pz,
	input  logic [31:0]         radius,
	input  qvp_pkg::view_cfg_t  cfg,
	output logic                out_vld,
	output qvp_pkg::rot_t       out_d
);
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [qvp_pkg::V_W-1:0]  vx_s1, vy_s1, vz_s1;
	logic signed [qvp_pkg::PA_W-1:0] tp_s2 [12];
	logic signed [qvp_pkg::T_W-1:0]  tw_s3, tx_s3, ty_s3, tz_s3;
	logic signed [qvp_pkg::PB_W-1:0] rp_s4 [12];
	logic [31:0] rad_s1, rad_s2, rad_s3, rad_s4;
	qvp_pkg::rot_t r_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s1  <= qvp_pkg::V_W'(px) - qvp_pkg::V_W'(cfg.cam_x);
			vy_s1  <= qvp_pkg::V_W'(py) - qvp_pkg::V_W'(cfg.cam_y);
			vz_s1  <= qvp_pkg::V_W'(pz) - qvp_pkg::V_W'(cfg.cam_z);
			rad_s1 <= radius;

			// Products of t = v * conj(q).
			tp_s2[0]  <= vx_s1 * cfg.rot_x;
			tp_s2[1]  <= vy_s1 * cfg.rot_y;
			tp_s2[2]  <= vz_s1 * cfg.rot_z;
			tp_s2[3]  <= vx_s1 * cfg.rot_w;
			tp_s2[4]  <= vy_s1 * cfg.rot_z;
			tp_s2[5]  <= vz_s1 * cfg.rot_y;
			tp_s2[6]  <= vx_s1 * cfg.rot_z;
			tp_s2[7]  <= vy_s1 * cfg.rot_w;
			tp_s2[8]  <= vz_s1 * cfg.rot_x;
			tp_s2[9]  <= vx_s1 * cfg.rot_y;
			tp_s2[10] <= vy_s1 * cfg.rot_x;
			tp_s2[11] <= vz_s1 * cfg.rot_w;
			rad_s2    <= rad_s1;

			tw_s3  <= qvp_pkg::rnd_t(qvp_pkg::SA_W'(tp_s2[0]) + qvp_pkg::SA_W'(tp_s2[1])
				+ qvp_pkg::SA_W'(tp_s2[2]));
			tx_s3  <= qvp_pkg::rnd_t(qvp_pkg::SA_W'(tp_s2[3]) - qvp_pkg::SA_W'(tp_s2[4])
				+ qvp_pkg::SA_W'(tp_s2[5]));
			ty_s3  <= qvp_pkg::rnd_t(qvp_pkg::SA_W'(tp_s2[6]) + qvp_pkg::SA_W'(tp_s2[7])
				- qvp_pkg::SA_W'(tp_s2[8]));
			tz_s3  <= qvp_pkg::rnd_t(qvp_pkg::SA_W'(tp_s2[10]) - qvp_pkg::SA_W'(tp_s2[9])
				+ qvp_pkg::SA_W'(tp_s2[11]));
			rad_s3 <= rad_s2;

			// Products of r = q * t; the real part of r is not needed.
			rp_s4[0]  <= cfg.rot_w * tx_s3;
			rp_s4[1]  <= cfg.rot_x * tw_s3;
			rp_s4[2]  <= cfg.rot_y * tz_s3;
			rp_s4[3]  <= cfg.rot_z * ty_s3;
			rp_s4[4]  <= cfg.rot_w * ty_s3;
			rp_s4[5]  <= cfg.rot_x * tz_s3;
			rp_s4[6]  <= cfg.rot_y * tw_s3;
			rp_s4[7]  <= cfg.rot_z * tx_s3;
			rp_s4[8]  <= cfg.rot_w * tz_s3;
			rp_s4[9]  <= cfg.rot_x * ty_s3;
			rp_s4[10] <= cfg.rot_y * tx_s3;
			rp_s4[11] <= cfg.rot_z * tw_s3;
			rad_s4    <= rad_s3;

			r_s5.rx <= qvp_pkg::rnd_r(qvp_pkg::SB_W'(rp_s4[0]) + qvp_pkg::SB_W'(rp_s4[1])
				+ qvp_pkg::SB_W'(rp_s4[2]) - qvp_pkg::SB_W'(rp_s4[3]));
			r_s5.ry <= qvp_pkg::rnd_r(qvp_pkg::SB_W'(rp_s4[4]) - qvp_pkg::SB_W'(rp_s4[5])
				+ qvp_pkg::SB_W'(rp_s4[6]) + qvp_pkg::SB_W'(rp_s4[7]));
			r_s5.rz <= qvp_pkg::rnd_r(qvp_pkg::SB_W'(rp_s4[8]) + qvp_pkg::SB_W'(rp_s4[9])
				- qvp_pkg::SB_W'(rp_s4[10]) + qvp_pkg::SB_W'(rp_s4[11]));
			r_s5.radius <= rad_s4;
		end
	end

	assign out_vld = vld_s5;
	assign out_d   = r_s5;
endmodule
`default_nettype wire

FILE: src/qvp_measure.sv
// Squared length, pipelined square root and the two screen divisions.
// Depends on qvp_pkg; fed by qvp_rotate.
`default_nettype none
module qvp_measure #(
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_vld,
	input  qvp_pkg::rot_t               in_d,
	input  logic [qvp_pkg::SW_W-1:0]    sw_x,
	input  logic [qvp_pkg::SW_W-1:0]    sw_y,
	output logic                        out_vld,
	output qvp_pkg::geom_t              out_d
);
	localparam int HW_X = SCREEN_WIDTH / 2;
	localparam int HW_Y = SCREEN_HEIGHT / 2;
	localparam logic ODD_X = (SCREEN_WIDTH % 2) != 0;
	localparam logic ODD_Y = (SCREEN_HEIGHT % 2) != 0;
	localparam int NS = qvp_pkg::SQ_STEPS;

	logic [qvp_pkg::R_W-1:0] ax, ay, az;

	logic vld_s1, vld_s2, vld_o;
	logic [63:0] sqa_s1, sqb_s1, sqc_s1;
	logic        dsat_s1, behind_s1, plane_s1, negx_s1, negy_s1;
	logic [49:0] pxl_s1, pyl_s1;
	logic [48:0] pxh_s1, pyh_s1;
	logic [qvp_pkg::R_W-1:0] az_s1;
	logic [31:0] rad_s1, rad_s2;

	logic [63:0]              sqn_s2;
	logic                     dsat_s2, behind_s2, plane_s2, negx_s2, negy_s2;
	logic [qvp_pkg::N_W-1:0]  nx_s2, ny_s2;
	logic [qvp_pkg::D_W-1:0]  d_s2;
	logic [65:0]              sum;

	qvp_pkg::meas_t loop_s [NS+1];
	logic           loop_vld [NS+1];
	qvp_pkg::geom_t geom_o;

	function automatic qvp_pkg::geom_t out_next(input qvp_pkg::meas_t m);
		qvp_pkg::geom_t g;
		g.distance = m.sq.sat ? '1 : m.sq.root;
		g.radius   = m.radius;
		g.behind   = m.behind;
		g.plane    = m.plane;
		g.sx       = m.plane ? qvp_pkg::EYE_PLANE_POS : qvp_pkg::scr_final(m.scx, 13'(HW_X), ODD_X);
		g.sy       = m.plane ? qvp_pkg::EYE_PLANE_POS : qvp_pkg::scr_final(m.scy, 13'(HW_Y), ODD_Y);
		return g;
	endfunction

	assign ax  = qvp_pkg::mag(in_d.rx);
	assign ay  = qvp_pkg::mag(in_d.ry);
	assign az  = qvp_pkg::mag(in_d.rz);
	assign sum = 66'(sqa_s1) + 66'(sqb_s1) + 66'(sqc_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			loop_vld[0] <= 1'b0;
			vld_o       <= 1'b0;
		end else if (adv) begin
			vld_s1      <= in_vld;
			vld_s2      <= vld_s1;
			loop_vld[0] <= vld_s2;
			vld_o       <= loop_vld[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqa_s1    <= ax[31:0] * ax[31:0];
			sqb_s1    <= ay[31:0] * ay[31:0];
			sqc_s1    <= az[31:0] * az[31:0];
			dsat_s1   <= (|ax[qvp_pkg::R_W-1:32]) | (|ay[qvp_pkg::R_W-1:32])
				| (|az[qvp_pkg::R_W-1:32]);
			pxl_s1    <= sw_x * ax[20:0];
			pxh_s1    <= sw_x * ax[qvp_pkg::R_W-1:21];
			pyl_s1    <= sw_y * ay[20:0];
			pyh_s1    <= sw_y * ay[qvp_pkg::R_W-1:21];
			az_s1     <= az;
			negx_s1   <= in_d.rx[qvp_pkg::R_W-1] ^ in_d.rz[qvp_pkg::R_W-1];
			negy_s1   <= in_d.ry[qvp_pkg::R_W-1] ^ in_d.rz[qvp_pkg::R_W-1];
			behind_s1 <= in_d.rz[qvp_pkg::R_W-1];
			plane_s1  <= in_d.rz == '0;
			rad_s1    <= in_d.radius;

			sqn_s2    <= sum[63:0];
			dsat_s2   <= dsat_s1 | (|sum[65:64]);
			nx_s2     <= (qvp_pkg::N_W'(pxh_s1) << 21) + qvp_pkg::N_W'(pxl_s1);
			ny_s2     <= (qvp_pkg::N_W'(pyh_s1) << 21) + qvp_pkg::N_W'(pyl_s1);
			d_s2      <= {az_s1, 13'b0};
			negx_s2   <= negx_s1;
			negy_s2   <= negy_s1;
			behind_s2 <= behind_s1;
			plane_s2  <= plane_s1;
			rad_s2    <= rad_s1;

			// The quotient overflows 20 bits exactly when the top bits reach the divisor.
			loop_s[0].sq.rem   <= '0;
			loop_s[0].sq.root  <= '0;
			loop_s[0].sq.nsh   <= sqn_s2;
			loop_s[0].sq.sat   <= dsat_s2;
			loop_s[0].scx.over <= qvp_pkg::D_W'(nx_s2[qvp_pkg::N_W-1:qvp_pkg::SC_STEPS]) >= d_s2;
			loop_s[0].scx.rem  <= qvp_pkg::D_W'(nx_s2[qvp_pkg::N_W-1:qvp_pkg::SC_STEPS]);
			loop_s[0].scx.d    <= d_s2;
			loop_s[0].scx.nsh  <= nx_s2[qvp_pkg::SC_STEPS-1:0];
			loop_s[0].scx.q    <= '0;
			loop_s[0].scx.neg  <= negx_s2;
			loop_s[0].scy.over <= qvp_pkg::D_W'(ny_s2[qvp_pkg::N_W-1:qvp_pkg::SC_STEPS]) >= d_s2;
			loop_s[0].scy.rem  <= qvp_pkg::D_W'(ny_s2[qvp_pkg::N_W-1:qvp_pkg::SC_STEPS]);
			loop_s[0].scy.d    <= d_s2;
			loop_s[0].scy.nsh  <= ny_s2[qvp_pkg::SC_STEPS-1:0];
			loop_s[0].scy.q    <= '0;
			loop_s[0].scy.neg  <= negy_s2;
			loop_s[0].radius   <= rad_s2;
			loop_s[0].behind   <= behind_s2;
			loop_s[0].plane    <= plane_s2;

			geom_o <= out_next(loop_s[NS]);
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				loop_vld[k+1] <= 1'b0;
			else if (adv)
				loop_vld[k+1] <= loop_vld[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				loop_s[k+1].sq     <= qvp_pkg::sqrt_step(loop_s[k].sq);
				loop_s[k+1].radius <= loop_s[k].radius;
				loop_s[k+1].behind <= loop_s[k].behind;
				loop_s[k+1].plane  <= loop_s[k].plane;
				if (k < qvp_pkg::SC_STEPS) begin
					loop_s[k+1].scx <= qvp_pkg::scr_step(loop_s[k].scx);
					loop_s[k+1].scy <= qvp_pkg::scr_step(loop_s[k].scy);
				end else begin
					loop_s[k+1].scx <= loop_s[k].scx;
					loop_s[k+1].scy <= loop_s[k].scy;
				end
			end
		end
	end

	assign out_vld = vld_o;
	assign out_d   = geom_o;
endmodule
`default_nettype wire

FILE: src/qvp_radius_div.sv
// Pipelined division of the sphere radius by the view distance, one bit a stage.
// Depends on qvp_pkg; fed by qvp_measure.
`default_nettype none
module qvp_radius_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           in_vld,
	input  qvp_pkg::geom_t in_d,
	output logic           out_vld,
	output qvp_pkg::rd_t   out_d
);
	localparam int NS = qvp_pkg::RD_STEPS;

	qvp_pkg::rd_t rd_s [NS+1];
	logic         rd_vld [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_vld[0] <= 1'b0;
		else if (adv)
			rd_vld[0] <= in_vld;
	end

	// A quotient of 2^32 or more shows already in the upper radius half; a zero
	// distance falls into the same case.
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s[0].dv.rem <= {16'b0, in_d.radius[31:16]};
			rd_s[0].dv.d   <= in_d.distance;
			rd_s[0].dv.nsh <= {in_d.radius[15:0], 16'b0};
			rd_s[0].dv.q   <= '0;
			rd_s[0].dv.sat <= {16'b0, in_d.radius[31:16]} >= in_d.distance;
			rd_s[0].sx     <= in_d.sx;
			rd_s[0].sy     <= in_d.sy;
			rd_s[0].behind <= in_d.behind;
			rd_s[0].plane  <= in_d.plane;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				rd_vld[k+1] <= 1'b0;
			else if (adv)
				rd_vld[k+1] <= rd_vld[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rd_s[k+1].dv     <= qvp_pkg::rdiv_step(rd_s[k].dv);
				rd_s[k+1].sx     <= rd_s[k].sx;
				rd_s[k+1].sy     <= rd_s[k].sy;
				rd_s[k+1].behind <= rd_s[k].behind;
				rd_s[k+1].plane  <= rd_s[k].plane;
			end
		end
	end

	assign out_vld = rd_vld[NS];
	assign out_d   = rd_s[NS];
endmodule
`default_nettype wire

FILE: src/quaternion_view_project.sv
// Top level of the quaternion view transform and perspective projection.
// Depends on qvp_pkg, the two channel interfaces, qvp_rotate, qvp_measure,
// qvp_radius_div and the assertion macro header.
`default_nettype none
`include "quaternion_view_project_macros.svh"

// This block takes one point request per clock and returns one result request per
// point, in order, after five stages of translate and rotate, three stages of
// squared length and screen numerators, 33 stages of the square root (with the 20
// screen division stages running beside it), 33 stages of the radius division, and
// the output register. The sustained rate is one point per cycle; every stage is a
// single shared enable, so when the result side holds ready low on a waiting result
// the whole pipeline freezes and the input ready drops with it. Configuration writes
// are registered and must only be made while no point is in flight.
module quaternion_view_project #(
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	qvp_point_if.sink           points,
	qvp_result_if.source        results
);
	// Configuration registers; the scale is premultiplied by each screen size so that
	// the measure stage needs only one multiplier per partial product.
	qvp_pkg::view_cfg_t            cfg_q;
	logic [15:0]                   scale_q;
	logic [qvp_pkg::SW_W-1:0]      sw_x_q, sw_y_q;

	logic adv;
	logic rot_vld, geo_vld, rd_vld;
	qvp_pkg::rot_t  rot_d;
	qvp_pkg::geom_t geo_d;
	qvp_pkg::rd_t   rd_d;

	logic               out_vld_q;
	logic signed [15:0] sx_q, sy_q;
	logic [31:0]        dist_q, prad_q;
	logic               behind_q, plane_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cam_x <= '0;
			cfg_q.cam_y <= '0;
			cfg_q.cam_z <= '0;
			cfg_q.rot_w <= 16'sd16384;
			cfg_q.rot_x <= '0;
			cfg_q.rot_y <= '0;
			cfg_q.rot_z <= '0;
			scale_q     <= 16'd4096;
			sw_x_q      <= qvp_pkg::SW_W'(4096 * SCREEN_WIDTH);
			sw_y_q      <= qvp_pkg::SW_W'(4096 * SCREEN_HEIGHT);
		end else begin
			sw_x_q <= qvp_pkg::SW_W'(scale_q * qvp_pkg::SW_W'(SCREEN_WIDTH));
			sw_y_q <= qvp_pkg::SW_W'(scale_q * qvp_pkg::SW_W'(SCREEN_HEIGHT));
			if (cfg_we) begin
				unique case (qvp_pkg::reg_idx_t'(cfg_index))
					qvp_pkg::REG_CAM_X: cfg_q.cam_x <= cfg_data;
					qvp_pkg::REG_CAM_Y: cfg_q.cam_y <= cfg_data;
					qvp_pkg::REG_CAM_Z: cfg_q.cam_z <= cfg_data;
					qvp_pkg::REG_ROT_W: cfg_q.rot_w <= cfg_data[15:0];
					qvp_pkg::REG_ROT_X: cfg_q.rot_x <= cfg_data[15:0];
					qvp_pkg::REG_ROT_Y: cfg_q.rot_y <= cfg_data[15:0];
					qvp_pkg::REG_ROT_Z: cfg_q.rot_z <= cfg_data[15:0];
					qvp_pkg::REG_SCALE: scale_q     <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	// The pipeline moves whenever the output register is empty or being drained.
	assign adv           = !out_vld_q || results.ready;
	assign points.ready  = adv;

	qvp_rotate u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (points.valid),
		.px      (points.point_x),
		.py      (points.point_y),
		.pz      (points.point_z),
		.radius  (points.obj_radius),
		.cfg     (cfg_q),
		.out_vld (rot_vld),
		.out_d   (rot_d)
	);

	qvp_measure #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_measure (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (rot_vld),
		.in_d    (rot_d),
		.sw_x    (sw_x_q),
		.sw_y    (sw_y_q),
		.out_vld (geo_vld),
		.out_d   (geo_d)
	);

	qvp_radius_div u_radius_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (geo_vld),
		.in_d    (geo_d),
		.out_vld (rd_vld),
		.out_d   (rd_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (adv)
			out_vld_q <= rd_vld;
	end

	// Points behind the camera get a zero radius; a saturated quotient, including
	// the zero distance case, gives all ones.
	always_ff @(posedge clk) begin
		if (adv) begin
			sx_q     <= rd_d.sx;
			sy_q     <= rd_d.sy;
			dist_q   <= rd_d.dv.d;
			prad_q   <= rd_d.behind ? '0 : (rd_d.dv.sat ? '1 : rd_d.dv.q);
			behind_q <= rd_d.behind;
			plane_q  <= rd_d.plane;
		end
	end

	assign results.valid         = out_vld_q;
	assign results.screen_x      = sx_q;
	assign results.screen_y      = sy_q;
	assign results.view_distance = dist_q;
	assign results.proj_radius   = prad_q;
	assign results.behind_camera = behind_q;
	assign results.on_eye_plane  = plane_q;

	// A point cannot lie both behind the camera and on the eye plane.
	`QVP_ASSERT(a_flags_exclusive, clk, arst_n, !(out_vld_q && behind_q && plane_q), "behind and eye plane both set")
	// The radius path and the sign flag must agree.
	`QVP_ASSERT(a_behind_zero_radius, clk, arst_n, !(out_vld_q && behind_q) || prad_q == '0, "radius not zero behind camera")
	// The eye plane substitute must reach both screen coordinates.
	`QVP_ASSERT(a_plane_position, clk, arst_n, !(out_vld_q && plane_q) || (sx_q == qvp_pkg::EYE_PLANE_POS && sy_q == qvp_pkg::EYE_PLANE_POS), "eye plane position wrong")
	// A held result keeps its distance while the sink stalls.
	`QVP_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_vld_q && !results.ready, out_vld_q && $stable(dist_q) && $stable(prad_q), "stalled result changed")
endmodule
`default_nettype wire
